/* hdl/sha256d_header_nonce_check_core_macros.svh */
// Assertion macros shared by the hashing core.
`ifndef SHA256D_HEADER_NONCE_CHECK_CORE_MACROS_SVH
`define SHA256D_HEADER_NONCE_CHECK_CORE_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define SHD_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Checks an implication whose consequent must hold in the next cycle, outside reset.
`define SHD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hdl/shd_pkg.sv */
package shd_pkg;

	localparam int unsigned NumRounds = 64;
	localparam int unsigned NumPasses = 3;
	localparam int unsigned PipeDepth = NumPasses * NumRounds + 1;

	localparam logic [31:0] PadWord      = 32'h80000000;
	localparam logic [31:0] HeaderBits   = 32'h00000280;
	localparam logic [31:0] DigestBits   = 32'd256;
	// Address of the top_word_limit register.
	localparam logic [1:0]  AddrTopLimit = 2'b00;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] state_t;
	typedef word_t [15:0] sched_t;

	typedef struct packed {
		logic [63:0] block_words_0_1;
		logic [63:0] block_words_2_3;
		logic [63:0] block_words_4_5;
		logic [63:0] block_words_6_7;
		logic [63:0] block_words_8_9;
		logic [63:0] block_words_10_11;
		logic [63:0] block_words_12_13;
		logic [63:0] block_words_14_15;
		logic [63:0] tail_word_and_time;
		logic [31:0] difficulty_bits;
		logic [31:0] nonce_value;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_words_0_1;
		logic [63:0] digest_words_2_3;
		logic [63:0] digest_words_4_5;
		logic [63:0] digest_words_6_7;
		logic        hit;
	} out_item_t;

	// Initial hash state.
	localparam state_t ShaIv = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	function automatic word_t round_k(input logic [5:0] idx);
		word_t k;
		case (idx)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t swap_bytes(input word_t x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

/* hdl/shd_round.sv */
// One SHA-256 round plus one message-schedule step, registered.
module shd_round #(
	parameter logic [5:0] RoundIdx = 6'd0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  shd_pkg::state_t st_in,
	input  shd_pkg::sched_t w_in,
	input  shd_pkg::state_t base_in,
	input  shd_pkg::state_t aux_in,
	output logic            valid_out,
	output shd_pkg::state_t st_out,
	output shd_pkg::sched_t w_out,
	output shd_pkg::state_t base_out,
	output shd_pkg::state_t aux_out
);
	import shd_pkg::*;

	word_t t1, t2, s0, s1, w_next;
	state_t st_next;

	// Round function on the working variables, using window word 0.
	always_comb begin
		t1 = st_in[7] + (rotr(st_in[4], 6) ^ rotr(st_in[4], 11) ^ rotr(st_in[4], 25))
			+ ((st_in[4] & st_in[5]) ^ (~st_in[4] & st_in[6]))
			+ round_k(RoundIdx) + w_in[0];
		t2 = (rotr(st_in[0], 2) ^ rotr(st_in[0], 13) ^ rotr(st_in[0], 22))
			+ ((st_in[0] & st_in[1]) ^ (st_in[0] & st_in[2]) ^ (st_in[1] & st_in[2]));
		st_next[0] = t1 + t2;
		st_next[1] = st_in[0];
		st_next[2] = st_in[1];
		st_next[3] = st_in[2];
		st_next[4] = st_in[3] + t1;
		st_next[5] = st_in[4];
		st_next[6] = st_in[5];
		st_next[7] = st_in[6];
		s0 = rotr(w_in[1], 7) ^ rotr(w_in[1], 18) ^ (w_in[1] >> 3);
		s1 = rotr(w_in[14], 17) ^ rotr(w_in[14], 19) ^ (w_in[14] >> 10);
		w_next = w_in[0] + s0 + w_in[9] + s1;
	end

	// Valid bit is reset; payload registers are not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out   <= st_next;
			w_out    <= {w_next, w_in[15:1]};
			base_out <= base_in;
			aux_out  <= aux_in;
		end
	end

endmodule

/* hdl/sha256d_header_nonce_check_core.sv */
// Pipeline: three 64-round passes of round registers, the last of which feeds the output
// register.
// Throughput: one item per cycle while the output is not stalled; one round register stage per SHA-256 round.
// The whole pipeline advances together and holds when the output register is full and stalled.
// Reset: arst_n clears all valid bits and sets top_word_limit to zero.
module sha256d_header_nonce_check_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  shd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output shd_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import shd_pkg::*;
	`include "sha256d_header_nonce_check_core_macros.svh"

	localparam int unsigned NumStages = NumPasses * NumRounds;

	logic        en;
	logic [31:0] limit_q;

	// Register port.
	assign pready = 1'b1;
	assign prdata = (paddr == AddrTopLimit) ? limit_q : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 32'h0;
		end else if (psel && penable && pwrite && paddr == AddrTopLimit) begin
			limit_q <= pwdata;
		end
	end

	// Global advance: stall only when the output holds an untaken item.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic   v   [NumStages+1];
	state_t st  [NumStages+1];
	sched_t w   [NumStages+1];
	state_t bs  [NumStages+1];
	state_t ax  [NumStages+1];
	state_t st_i[NumStages];
	sched_t w_i [NumStages];
	state_t bs_i[NumStages];
	state_t ax_i[NumStages];

	// Pass 1 source: header words 0..15; aux carries second-block words.
	assign v[0]  = in_valid;
	assign st[0] = ShaIv;
	assign bs[0] = ShaIv;
	assign w[0]  = {in_data.block_words_14_15[31:0], in_data.block_words_14_15[63:32],
		in_data.block_words_12_13[31:0], in_data.block_words_12_13[63:32],
		in_data.block_words_10_11[31:0], in_data.block_words_10_11[63:32],
		in_data.block_words_8_9[31:0], in_data.block_words_8_9[63:32],
		in_data.block_words_6_7[31:0], in_data.block_words_6_7[63:32],
		in_data.block_words_4_5[31:0], in_data.block_words_4_5[63:32],
		in_data.block_words_2_3[31:0], in_data.block_words_2_3[63:32],
		in_data.block_words_0_1[31:0], in_data.block_words_0_1[63:32]};
	assign ax[0] = {128'h0, swap_bytes(in_data.nonce_value), in_data.difficulty_bits,
		in_data.tail_word_and_time[31:0], in_data.tail_word_and_time[63:32]};

	genvar gi;
	generate
		for (gi = 0; gi < NumStages; gi++) begin : g_round
			if (gi == NumRounds) begin : g_p2
				state_t fin;
				// Add feed-forward of the first block and load the second block.
				always_comb begin
					for (int j = 0; j < 8; j++) begin
						fin[j] = bs[gi][j] + st[gi][j];
					end
				end
				assign st_i[gi] = fin;
				assign bs_i[gi] = fin;
				assign w_i[gi]  = {HeaderBits, 320'h0, PadWord, ax[gi][3], ax[gi][2],
					ax[gi][1], ax[gi][0]};
				assign ax_i[gi] = ax[gi];
			end else if (gi == 2 * NumRounds) begin : g_p3
				state_t fin;
				// Add feed-forward of the second block and start the outer hash.
				always_comb begin
					for (int j = 0; j < 8; j++) begin
						fin[j] = bs[gi][j] + st[gi][j];
					end
				end
				assign st_i[gi] = ShaIv;
				assign bs_i[gi] = ShaIv;
				assign w_i[gi]  = {DigestBits, 192'h0, PadWord, fin[7], fin[6], fin[5],
					fin[4], fin[3], fin[2], fin[1], fin[0]};
				assign ax_i[gi] = ax[gi];
			end else begin : g_mid
				assign st_i[gi] = st[gi];
				assign bs_i[gi] = bs[gi];
				assign w_i[gi]  = w[gi];
				assign ax_i[gi] = ax[gi];
			end
			shd_round #(.RoundIdx(6'(gi % NumRounds))) u_round (
				.clk(clk), .arst_n(arst_n), .en(en), .valid_in(v[gi]),
				.st_in(st_i[gi]), .w_in(w_i[gi]), .base_in(bs_i[gi]), .aux_in(ax_i[gi]),
				.valid_out(v[gi+1]), .st_out(st[gi+1]), .w_out(w[gi+1]),
				.base_out(bs[gi+1]), .aux_out(ax[gi+1]));
		end
	endgenerate

	// Final feed-forward, limit compare and output register.
	state_t dig;
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			dig[j] = bs[NumStages][j] + st[NumStages][j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v[NumStages];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.digest_words_0_1 <= {dig[0], dig[1]};
			out_data.digest_words_2_3 <= {dig[2], dig[3]};
			out_data.digest_words_4_5 <= {dig[4], dig[5]};
			out_data.digest_words_6_7 <= {dig[6], dig[7]};
			out_data.hit <= (swap_bytes(dig[7]) <= limit_q);
		end
	end

	// A stalled result stays valid and unchanged.
	`SHD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped under stall")
	// Input is not taken while the output holds an untaken item.
	`SHD_ASSERT_IMPL(a_ready_en, clk, arst_n, out_valid && !out_ready, !in_ready, "input taken during stall")
	// A stalled first stage keeps its valid bit.
	`SHD_ASSERT_NEXT(a_s1_hold, clk, arst_n, !en && v[1], v[1], "stage one lost item on stall")

endmodule

/* test/sha256d_header_nonce_check_core_tb.sv */
module sha256d_header_nonce_check_core_tb;
	import shd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LatencyCycles = 192;
	localparam int unsigned CycleLimit = 1500000;

	// Idle patterns for the sender and the receiver.
	typedef enum int {
		PhaseSteady,
		PhaseSenderIdle,
		PhaseReceiverStall,
		PhaseBothIdle
	} traffic_phase_e;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	in_item_t header_queue[$];
	out_item_t digest_queue[$];
	logic [31:0] limit_model;
	traffic_phase_e phase;
	bit hold_off;
	int unsigned hold_count;
	int unsigned error_count;
	int unsigned cycle_count;

	sha256d_header_nonce_check_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Round constants, kept here so the prediction does not lean on the design package.
	function automatic word_t round_const(input int unsigned idx);
		word_t k_table[64];
		k_table = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k_table[idx];
	endfunction

	function automatic word_t ror32(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t flip_bytes(input word_t x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic state_t initial_state();
		state_t st;
		st[0] = 32'h6a09e667; st[1] = 32'hbb67ae85; st[2] = 32'h3c6ef372;
		st[3] = 32'ha54ff53a; st[4] = 32'h510e527f; st[5] = 32'h9b05688c;
		st[6] = 32'h1f83d9ab; st[7] = 32'h5be0cd19;
		return st;
	endfunction

	// One SHA-256 compression of a 16-word block into the running state.
	function automatic state_t sha_compress(input state_t st, input sched_t blk);
		word_t w[64];
		word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = st[0]; b = st[1]; c = st[2]; d = st[3];
		e = st[4]; f = st[5]; g = st[6]; h = st[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ round_const(i) + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		st[0] += a; st[1] += b; st[2] += c; st[3] += d;
		st[4] += e; st[5] += f; st[6] += g; st[7] += h;
		return st;
	endfunction

	// Double hash of the header with the nonce, plus the target check.
	function automatic out_item_t header_digest(input in_item_t it, input logic [31:0] limit);
		sched_t blk;
		state_t st;
		state_t first;
		logic [63:0] pairs[8];
		out_item_t res;
		pairs = '{it.block_words_0_1, it.block_words_2_3, it.block_words_4_5,
			it.block_words_6_7, it.block_words_8_9, it.block_words_10_11,
			it.block_words_12_13, it.block_words_14_15};
		for (int i = 0; i < 8; i++) begin
			blk[2*i] = pairs[i][63:32];
			blk[2*i+1] = pairs[i][31:0];
		end
		st = sha_compress(initial_state(), blk);
		blk = '0;
		blk[0] = it.tail_word_and_time[63:32];
		blk[1] = it.tail_word_and_time[31:0];
		blk[2] = it.difficulty_bits;
		blk[3] = flip_bytes(it.nonce_value);
		blk[4] = 32'h80000000;
		blk[15] = 32'h00000280;
		first = sha_compress(st, blk);
		blk = '0;
		for (int i = 0; i < 8; i++) blk[i] = first[i];
		blk[8] = 32'h80000000;
		blk[15] = 32'd256;
		st = sha_compress(initial_state(), blk);
		res.digest_words_0_1 = {st[0], st[1]};
		res.digest_words_2_3 = {st[2], st[3]};
		res.digest_words_4_5 = {st[4], st[5]};
		res.digest_words_6_7 = {st[6], st[7]};
		res.hit = (flip_bytes(st[7]) <= limit);
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t random_header();
		in_item_t it;
		it.block_words_0_1 = rand64();
		it.block_words_2_3 = rand64();
		it.block_words_4_5 = rand64();
		it.block_words_6_7 = rand64();
		it.block_words_8_9 = rand64();
		it.block_words_10_11 = rand64();
		it.block_words_12_13 = rand64();
		it.block_words_14_15 = rand64();
		it.tail_word_and_time = rand64();
		it.difficulty_bits = $urandom;
		it.nonce_value = $urandom;
		return it;
	endfunction

	// Driver: offers queued items, with idle gaps set by the phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (header_queue.size() > 0 &&
				!((phase == PhaseSenderIdle || phase == PhaseBothIdle) &&
				$urandom_range(99) < 73)) begin
				in_valid <= 1'b1;
				in_data <= header_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Predict every accepted item.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			digest_queue.push_back(header_digest(in_data, limit_model));
	end

	// Receiver ready, with random stalls and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_count <= 0;
		end else if (hold_off && hold_count < 600) begin
			out_ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= !((phase == PhaseReceiverStall || phase == PhaseBothIdle) &&
				$urandom_range(99) < 73);
		end
	end

	// Monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (digest_queue.size() == 0) begin
				$error("unexpected result item");
				error_count++;
			end else begin
				want = digest_queue.pop_front();
				if (out_data.digest_words_0_1 !== want.digest_words_0_1) begin
					$error("digest_words_0_1 expected %h got %h",
						want.digest_words_0_1, out_data.digest_words_0_1);
					error_count++;
				end
				if (out_data.digest_words_2_3 !== want.digest_words_2_3) begin
					$error("digest_words_2_3 expected %h got %h",
						want.digest_words_2_3, out_data.digest_words_2_3);
					error_count++;
				end
				if (out_data.digest_words_4_5 !== want.digest_words_4_5) begin
					$error("digest_words_4_5 expected %h got %h",
						want.digest_words_4_5, out_data.digest_words_4_5);
					error_count++;
				end
				if (out_data.digest_words_6_7 !== want.digest_words_6_7) begin
					$error("digest_words_6_7 expected %h got %h",
						want.digest_words_6_7, out_data.digest_words_6_7);
					error_count++;
				end
				if (out_data.hit !== want.hit) begin
					$error("hit expected %b got %b", want.hit, out_data.hit);
					error_count++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("sha256d_header_nonce_check_core_tb: done, errors");
			$finish;
		end
	end

	// Register write: setup cycle, then access cycle.
	task automatic write_limit(input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrTopLimit;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		limit_model = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (header_queue.size() > 0 || in_valid || digest_queue.size() > 0)
			@(posedge clk);
		repeat (LatencyCycles + 10) @(posedge clk);
	endtask

	initial begin
		in_item_t it;
		logic [31:0] limits[5];
		traffic_phase_e phases[4];
		cycle_count = 0;
		error_count = 0;
		limit_model = '0;
		phase = PhaseSteady;
		hold_off = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: all zeros, all ones, nonce extremes, an alternating pattern, reset limit.
		it = '0;
		header_queue.push_back(it);
		it = '1;
		header_queue.push_back(it);
		for (int i = 0; i < 8; i++) begin
			it = random_header();
			it.nonce_value = (i[0]) ? 32'hffffffff : 32'h0;
			it.difficulty_bits = 32'h1d00ffff;
			header_queue.push_back(it);
		end
		it = {10{32'haaaaaaaa, 32'h55555555}};
		header_queue.push_back(it);
		drain();

		// Limit of all ones hits every item.
		write_limit(32'hffffffff);
		for (int i = 0; i < 6; i++) header_queue.push_back(random_header());
		drain();

		// Random part across phases and limit settings, extremes included.
		limits = '{32'h0, 32'hffffffff, 32'h80000000, 32'h00ffffff, 32'h0};
		phases = '{PhaseSteady, PhaseSenderIdle, PhaseReceiverStall, PhaseBothIdle};
		for (int p = 0; p < 5; p++) begin
			if (p == 2) limits[p] = $urandom;
			write_limit(limits[p]);
			phase = phases[p % 4];
			for (int i = 0; i < 255; i++) header_queue.push_back(random_header());
			if (p == 0) begin
				// Long receiver hold-off while the sender keeps offering items.
				hold_off = 1'b1;
			end
			drain();
			hold_off = 1'b0;
		end

		if (error_count == 0) begin
			$display("sha256d_header_nonce_check_core_tb: done, clean");
		end else begin
			$display("sha256d_header_nonce_check_core_tb: done, errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/shd_pkg.sv
hdl/shd_round.sv
hdl/sha256d_header_nonce_check_core.sv
test/sha256d_header_nonce_check_core_tb.sv
